/* hw/rtl/mlp_pkg.sv */
// Shared constants, types and the logistic table of the network core.
`default_nettype none
package mlp_pkg;
  localparam int MAX_INPUTS = 32;
  localparam int MAX_LAYERS = 4;
  localparam int MAX_HEIGHT = 16;
  localparam int VALUE_BITS = 16;

  localparam int IN_W    = $clog2(MAX_INPUTS);
  localparam int NODE_W  = $clog2(MAX_HEIGHT);
  localparam int LAYER_W = $clog2(MAX_LAYERS);
  localparam int CNT_W   = $clog2(MAX_INPUTS + 1);
  localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int LCNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int W_DEPTH = MAX_INPUTS + (MAX_LAYERS - 1) * MAX_HEIGHT;
  localparam int WA_W    = $clog2(W_DEPTH);
  localparam int N_DEPTH = MAX_LAYERS * MAX_HEIGHT;
  localparam int NA_W    = $clog2(N_DEPTH);
  localparam int ACT_W   = 13;
  localparam int X_W     = VALUE_BITS + 1;
  localparam int PROD_W  = X_W + VALUE_BITS;
  localparam int ACC_W   = PROD_W + CNT_W;
  localparam int FRAC_BITS = 12;

  localparam logic [1:0] KIND_INPUT  = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;

  localparam logic [1:0] REG_INPUTS = 2'd0;
  localparam logic [1:0] REG_LAYERS = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_DRAIN, ST_SHIFT, ST_WAIT
  } state_e;

  typedef struct packed {
    logic            clear;
    logic            mac;
    logic            shift;
    logic            rd;
    logic [WA_W-1:0] rd_addr;
  } cell_ctl_t;

  typedef struct packed {
    logic [WA_W-1:0]              addr;
    logic signed [VALUE_BITS-1:0] data;
  } wt_wr_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [LAYER_W-1:0] layer;
    logic               out_en;
    logic               last;
  } act_tag_t;

  function automatic logic [ACT_W-1:0] sig_lut(input logic [4:0] i);
    logic [ACT_W-1:0] r;
    case (i)
      5'd0:  r = 13'd2048;
      5'd1:  r = 13'd2550;
      5'd2:  r = 13'd2994;
      5'd3:  r = 13'd3349;
      5'd4:  r = 13'd3608;
      5'd5:  r = 13'd3785;
      5'd6:  r = 13'd3902;
      5'd7:  r = 13'd3976;
      5'd8:  r = 13'd4022;
      5'd9:  r = 13'd4051;
      5'd10: r = 13'd4069;
      5'd11: r = 13'd4079;
      5'd12: r = 13'd4086;
      5'd13: r = 13'd4090;
      5'd14: r = 13'd4092;
      5'd15: r = 13'd4094;
      default: r = 13'd4095;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* hw/rtl/mlp_cell.sv */
// One node cell: private weight memory, multiply-accumulate and shift link.
`default_nettype none
module mlp_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mlp_pkg::cell_ctl_t                ctl_i,
  input  wire logic                              we_i,
  input  wire mlp_pkg::wt_wr_t                   wr_i,
  input  wire logic signed [mlp_pkg::X_W-1:0]    x_i,
  input  wire logic signed [mlp_pkg::ACC_W-1:0]  acc_i,
  output logic signed [mlp_pkg::ACC_W-1:0]       acc_o
);
  import mlp_pkg::*;

  logic signed [VALUE_BITS-1:0] mem [W_DEPTH];
  logic signed [VALUE_BITS-1:0] w_q;
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [ACC_W-1:0]      acc_d;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[wr_i.addr] <= wr_i.data;
    if (ctl_i.rd) w_q <= mem[ctl_i.rd_addr];
  end

  assign prod = x_i * w_q;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) acc_d = '0;
    else if (ctl_i.shift) acc_d = acc_i;
    else if (ctl_i.mac) acc_d = acc_q + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

/* hw/rtl/mlp_act.sv */
// Two-stage rounding, saturation and interpolated logistic activation.
`default_nettype none
module mlp_act (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic signed [mlp_pkg::ACC_W-1:0]  acc_i,
  input  wire mlp_pkg::act_tag_t                 tag_i,
  output logic                                   valid_o,
  output logic [mlp_pkg::ACT_W-1:0]              value_o,
  output mlp_pkg::act_tag_t                      tag_o
);
  import mlp_pkg::*;

  localparam int SH_W = ACC_W - FRAC_BITS;

  logic signed [ACC_W-1:0]      rnd;
  logic signed [SH_W-1:0]       sh;
  logic signed [VALUE_BITS-1:0] sat;
  logic signed [VALUE_BITS-1:0] x_q;
  logic                         v1_q;
  act_tag_t                     t1_q;
  logic [VALUE_BITS-1:0]        mag;
  logic [4:0]                   seg;
  logic [10:0]                  frac;
  logic [ACT_W-1:0]             t_lo;
  logic [ACT_W-1:0]             t_hi;
  logic [ACT_W+10:0]            slope;
  logic [ACT_W-1:0]             s;
  logic [ACT_W-1:0]             res;
  logic                         v2_q;
  act_tag_t                     t2_q;
  logic [ACT_W-1:0]             val_q;

  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SH_W'(1 << (VALUE_BITS - 1));

  always_comb begin
    rnd = acc_i + ACC_W'(1 << (FRAC_BITS - 1));
    sh  = SH_W'(rnd >>> FRAC_BITS);
    if (sh > SAT_HI) sat = SAT_HI[VALUE_BITS-1:0];
    else if (sh < SAT_LO) sat = SAT_LO[VALUE_BITS-1:0];
    else sat = sh[VALUE_BITS-1:0];
  end

  always_comb begin
    mag   = x_q[VALUE_BITS-1] ? VALUE_BITS'(-x_q) : VALUE_BITS'(x_q);
    seg   = 5'(mag >> 11);
    frac  = mag[10:0];
    t_lo  = sig_lut(seg);
    t_hi  = sig_lut(5'(seg + 5'd1));
    slope = (ACT_W+11)'(t_hi - t_lo) * (ACT_W+11)'(frac) + (ACT_W+11)'(1024);
    if (seg >= 5'd16) s = sig_lut(5'd16);
    else s = t_lo + ACT_W'(slope >> 11);
    res = x_q[VALUE_BITS-1] ? ACT_W'(13'd4096 - s) : s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= sat;
    t1_q  <= tag_i;
    val_q <= res;
    t2_q  <= t1_q;
  end

  assign valid_o = v2_q;
  assign value_o = val_q;
  assign tag_o   = t2_q;
endmodule
`default_nettype wire

/* hw/rtl/mlp_forward_pass_core.sv */
// Top level: stores, sequencer, row of node cells and activation unit.
// Each layer of a run passes through a multiply-accumulate over n sources,
// a drain, the shift-out of H sums and a wait; n is the inputs (first layer)
// or H (later layers), H the layer height. Results leave through the
// activation input and value registers, one per cycle; the receiver cannot stall.
// Reset loads the registers to 32, 4 and 16 and clears the input store valid bits.
`default_nettype none
module mlp_forward_pass_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            kind_i,
  input  wire logic [1:0]                            layer_i,
  input  wire logic [4:0]                            source_i,
  input  wire logic [3:0]                            dest_i,
  input  wire logic signed [mlp_pkg::VALUE_BITS-1:0] data_i,
  input  wire logic                                  cfg_we_i,
  input  wire logic [1:0]                            cfg_idx_i,
  input  wire logic [5:0]                            cfg_data_i,
  output logic                                       result_valid_o,
  output logic [3:0]                                 node_index_o,
  output logic [12:0]                                node_value_o,
  output logic                                       last_o
);
  import mlp_pkg::*;

  logic [5:0] ni_q;
  logic [2:0] nl_q;
  logic [4:0] nh_q;
  logic [CNT_W-1:0]  ni;
  logic [LCNT_W-1:0] nl;
  logic [HCNT_W-1:0] nh;

  state_e state_q, state_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [LAYER_W-1:0] l_q, l_d;
  logic [NODE_W-1:0]  j_q, j_d;
  logic               w_q, w_d;
  logic               mac_q;

  logic accept;
  logic [CNT_W-1:0] n_src;
  cell_ctl_t ctl;
  wt_wr_t    wr;
  logic      wt_we;
  logic [MAX_HEIGHT-1:0] cell_we;

  logic signed [VALUE_BITS-1:0] in_mem [MAX_INPUTS];
  logic [MAX_INPUTS-1:0]        in_vld_q;
  logic [ACT_W-1:0]             node_mem [N_DEPTH];
  logic signed [X_W-1:0]        x_q;
  logic [NA_W-1:0]              n_rd_addr;

  logic signed [ACC_W-1:0] acc_link [MAX_HEIGHT+1];
  logic                    act_in_vld;
  act_tag_t                act_in_tag;
  logic                    act_vld;
  logic [ACT_W-1:0]        act_val;
  act_tag_t                act_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ni_q <= 6'(MAX_INPUTS);
      nl_q <= 3'(MAX_LAYERS);
      nh_q <= 5'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INPUTS: ni_q <= cfg_data_i;
        REG_LAYERS: nl_q <= cfg_data_i[2:0];
        REG_HEIGHT: nh_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ni_q == '0) ni = CNT_W'(1);
    else if (32'(ni_q) > MAX_INPUTS) ni = CNT_W'(MAX_INPUTS);
    else ni = CNT_W'(ni_q);
    if (nl_q == '0) nl = LCNT_W'(1);
    else if (32'(nl_q) > MAX_LAYERS) nl = LCNT_W'(MAX_LAYERS);
    else nl = LCNT_W'(nl_q);
    if (nh_q == '0) nh = HCNT_W'(1);
    else if (32'(nh_q) > MAX_HEIGHT) nh = HCNT_W'(MAX_HEIGHT);
    else nh = HCNT_W'(nh_q);
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    wt_we   = accept && (kind_i == KIND_WEIGHT) && (32'(dest_i) < MAX_HEIGHT) &&
              ((layer_i == '0) || ((32'(layer_i) < MAX_LAYERS) &&
                                   (32'(source_i) < MAX_HEIGHT)));
    wr.data = data_i;
    if (layer_i == '0) wr.addr = WA_W'(source_i);
    else wr.addr = WA_W'(MAX_INPUTS) + WA_W'(layer_i - 2'd1) * WA_W'(MAX_HEIGHT) +
                   WA_W'(source_i);
    for (int c = 0; c < MAX_HEIGHT; c++) begin
      cell_we[c] = wt_we && (32'(dest_i) == c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      l_q     <= '0;
      j_q     <= '0;
      w_q     <= 1'b0;
      mac_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      l_q     <= l_d;
      j_q     <= j_d;
      w_q     <= w_d;
      mac_q   <= ctl.rd;
    end
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    l_d         = l_q;
    j_d         = j_q;
    w_d         = w_q;
    ctl.clear   = 1'b0;
    ctl.mac     = mac_q;
    ctl.shift   = 1'b0;
    ctl.rd      = 1'b0;
    n_src       = (l_q == '0) ? ni : CNT_W'(nh);
    if (l_q == '0) ctl.rd_addr = WA_W'(k_q);
    else ctl.rd_addr = WA_W'(MAX_INPUTS) + WA_W'(l_q - 1'b1) * WA_W'(MAX_HEIGHT) +
                       WA_W'(k_q);
    act_in_vld  = 1'b0;
    act_in_tag.node   = j_q;
    act_in_tag.layer  = l_q;
    act_in_tag.out_en = (LCNT_W'(l_q) == nl - LCNT_W'(1));
    act_in_tag.last   = (HCNT_W'(j_q) == nh - HCNT_W'(1));
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KIND_RUN) begin
          ctl.clear = 1'b1;
          k_d       = '0;
          l_d       = '0;
          state_d   = ST_MAC;
        end
      end
      ST_MAC: begin
        ctl.rd = 1'b1;
        k_d    = k_q + CNT_W'(1);
        if (k_q == n_src - CNT_W'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        j_d     = '0;
        state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        ctl.shift  = 1'b1;
        act_in_vld = 1'b1;
        j_d        = j_q + NODE_W'(1);
        if (act_in_tag.last) begin
          w_d     = 1'b0;
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        w_d = 1'b1;
        if (w_q) begin
          if (act_in_tag.out_en) begin
            state_d = ST_IDLE;
          end else begin
            ctl.clear = 1'b1;
            l_d       = l_q + LAYER_W'(1);
            k_d       = '0;
            state_d   = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= '0;
    else if (accept && kind_i == KIND_INPUT) in_vld_q[source_i] <= 1'b1;
  end

  assign n_rd_addr = NA_W'(l_q - 1'b1) * NA_W'(MAX_HEIGHT) + NA_W'(k_q[NODE_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_INPUT) in_mem[source_i] <= data_i;
    if (act_vld) node_mem[NA_W'(act_tag.layer) * NA_W'(MAX_HEIGHT) +
                          NA_W'(act_tag.node)] <= act_val;
    if (ctl.rd) begin
      if (l_q == '0) begin
        if (in_vld_q[k_q[IN_W-1:0]])
          x_q <= {in_mem[k_q[IN_W-1:0]][VALUE_BITS-1], in_mem[k_q[IN_W-1:0]]};
        else
          x_q <= '0;
      end else begin
        x_q <= X_W'(node_mem[n_rd_addr]);
      end
    end
  end

  assign acc_link[MAX_HEIGHT] = '0;

  for (genvar c = 0; c < MAX_HEIGHT; c++) begin : g_cell
    mlp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .we_i   (cell_we[c]),
      .wr_i   (wr),
      .x_i    (x_q),
      .acc_i  (acc_link[c+1]),
      .acc_o  (acc_link[c])
    );
  end

  mlp_act u_act (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (act_in_vld),
    .acc_i   (acc_link[0]),
    .tag_i   (act_in_tag),
    .valid_o (act_vld),
    .value_o (act_val),
    .tag_o   (act_tag)
  );

  assign result_valid_o = act_vld && act_tag.out_en;
  assign node_index_o   = act_tag.node;
  assign node_value_o   = act_val;
  assign last_o         = act_tag.last;

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o)
    else $error("result after last transfer");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i == KIND_RUN |=> busy)
    else $error("run not started");

  a_mac_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_q |-> (state_q == ST_MAC || state_q == ST_DRAIN))
    else $error("accumulate outside sum phase");

  a_shift_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.shift |-> !mac_q)
    else $error("shift during accumulate");
endmodule
`default_nettype wire
